@@ rtl/usals_pkg.sv @@
// ----------------------------------------------------------------------------
// usals_pkg
// Shared constants, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package usals_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  // vector width (km * 2^8) and angle width (degrees * 2^16)
  localparam int VW = 28;
  localparam int ZW = 26;

  localparam logic signed [17:0] DEG90_Q8  = 18'sd23040;
  localparam logic signed [17:0] DEG180_Q8 = 18'sd46080;
  localparam logic signed [17:0] DEG360_Q8 = 18'sd92160;

  localparam longint R_EQ_Q8      = 64'sd1632804;
  localparam longint R_SAT_Q8     = 64'sd10794130;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;

  // radius times the inverse CORDIC gain, rounded to nearest
  localparam longint X0_EQ  = (R_EQ_Q8 * INV_GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
  localparam longint X0_SAT = (R_SAT_Q8 * INV_GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;

  localparam logic [15:0] CMD_EAST = 16'hE000;
  localparam logic [15:0] CMD_WEST = 16'hD000;

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/usals_rotor_angle_command.sv @@
// ----------------------------------------------------------------------------
// usals_rotor_angle_command
// Pipelined USALS motor angle and goto-angle command byte computation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   site_latitude, site_longitude,
//                                            satellite_longitude
// result    out        out_valid / out_ready rotor_byte_high, rotor_byte_low,
//                                            rotor_angle, range_error
//
// One transaction per cycle is accepted and one result per cycle delivered
// unless the output register is blocked. The pipeline holds an input
// reduction stage, one stage per rotation CORDIC iteration, a pointing vector
// stage, one stage per arctangent CORDIC iteration, and the output register.
// Reset clears only the stage valid bits. When the output register holds an
// untaken result the whole pipeline holds; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module usals_rotor_angle_command #(
  parameter int CORDIC_STAGES = usals_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] site_latitude,
  input  logic signed [16:0] site_longitude,
  input  logic signed [16:0] satellite_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  rotor_byte_high,
  output logic        [7:0]  rotor_byte_low,
  output logic signed [15:0] rotor_angle,
  output logic               range_error
);
  import usals_pkg::*;

  localparam int N = CORDIC_STAGES;

  // advance every stage together unless the output register is blocked
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- input reduction ----------------
  logic signed [17:0] lat_ext, diff, diff_red, lat_fold, diff_fold;
  logic               lat_neg, diff_neg;

  assign lat_ext = 18'(site_latitude);
  assign diff    = 18'(site_longitude) - 18'(satellite_longitude);

  always_comb begin
    // bring the longitude difference into [-180, 180)
    if (diff >= DEG180_Q8) begin
      diff_red = diff - DEG360_Q8;
    end else if (diff < -DEG180_Q8) begin
      diff_red = diff + DEG360_Q8;
    end else begin
      diff_red = diff;
    end
    // fold beyond +-90 degrees by 180, negating the result later
    lat_neg  = 1'b0;
    lat_fold = lat_ext;
    if (lat_ext > DEG90_Q8) begin
      lat_fold = lat_ext - DEG180_Q8;
      lat_neg  = 1'b1;
    end else if (lat_ext < -DEG90_Q8) begin
      lat_fold = lat_ext + DEG180_Q8;
      lat_neg  = 1'b1;
    end
    diff_neg  = 1'b0;
    diff_fold = diff_red;
    if (diff_red > DEG90_Q8) begin
      diff_fold = diff_red - DEG180_Q8;
      diff_neg  = 1'b1;
    end else if (diff_red < -DEG90_Q8) begin
      diff_fold = diff_red + DEG180_Q8;
      diff_neg  = 1'b1;
    end
  end

  // ---------------- rotation CORDIC stages ----------------
  logic                    rv [0:N];
  logic signed [VW-1:0]    ex [0:N];
  logic signed [VW-1:0]    ey [0:N];
  logic signed [ZW-1:0]    ez [0:N];
  logic signed [VW-1:0]    sx [0:N];
  logic signed [VW-1:0]    sy [0:N];
  logic signed [ZW-1:0]    sz [0:N];
  logic                    eneg [0:N];
  logic                    sneg [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= in_valid;
    end
    if (en) begin
      ex[0]   <= VW'(X0_EQ);
      ey[0]   <= '0;
      ez[0]   <= {lat_fold, 8'd0};
      eneg[0] <= lat_neg;
      sx[0]   <= VW'(X0_SAT);
      sy[0]   <= '0;
      sz[0]   <= {diff_fold, 8'd0};
      sneg[0] <= diff_neg;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (en) begin
        rv[k+1] <= rv[k];
      end
      if (en) begin
        eneg[k+1] <= eneg[k];
        sneg[k+1] <= sneg[k];
        if (ez[k] >= 0) begin
          ex[k+1] <= ex[k] - (ey[k] >>> k);
          ey[k+1] <= ey[k] + (ex[k] >>> k);
          ez[k+1] <= ez[k] - atan_q16(k);
        end else begin
          ex[k+1] <= ex[k] + (ey[k] >>> k);
          ey[k+1] <= ey[k] - (ex[k] >>> k);
          ez[k+1] <= ez[k] + atan_q16(k);
        end
        if (sz[k] >= 0) begin
          sx[k+1] <= sx[k] - (sy[k] >>> k);
          sy[k+1] <= sy[k] + (sx[k] >>> k);
          sz[k+1] <= sz[k] - atan_q16(k);
        end else begin
          sx[k+1] <= sx[k] + (sy[k] >>> k);
          sy[k+1] <= sy[k] - (sx[k] >>> k);
          sz[k+1] <= sz[k] + atan_q16(k);
        end
      end
    end
  end

  // ---------------- pointing vector ----------------
  logic signed [VW-1:0] dish_x, sat_x, sat_y, px, py;
  assign dish_x = eneg[N] ? -ex[N] : ex[N];
  assign sat_x  = sneg[N] ? -sx[N] : sx[N];
  assign sat_y  = sneg[N] ? -sy[N] : sy[N];
  assign px     = sat_x - dish_x;
  assign py     = sat_y;

  logic                 av [0:N];
  logic signed [VW-1:0] ax [0:N];
  logic signed [VW-1:0] ay [0:N];
  logic signed [ZW-1:0] az [0:N];
  logic                 aerr [0:N];
  logic                 azero [0:N];
  logic                 ypos [0:N];
  logic                 yneg [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      av[0] <= 1'b0;
    end else if (en) begin
      av[0] <= rv[N];
    end
    if (en) begin
      aerr[0]  <= (px <= 0);
      azero[0] <= (px == 0);
      ypos[0]  <= (py > 0);
      yneg[0]  <= (py < 0);
      // work on the negated vector when x is negative
      ax[0]    <= (px < 0) ? -px : px;
      ay[0]    <= (px < 0) ? -py : py;
      az[0]    <= '0;
    end
  end

  // ---------------- arctangent CORDIC stages ----------------
  for (genvar k = 0; k < N; k++) begin : g_atan
    always_ff @(posedge clk) begin
      if (rst) begin
        av[k+1] <= 1'b0;
      end else if (en) begin
        av[k+1] <= av[k];
      end
      if (en) begin
        aerr[k+1]  <= aerr[k];
        azero[k+1] <= azero[k];
        ypos[k+1]  <= ypos[k];
        yneg[k+1]  <= yneg[k];
        if (ay[k] < 0) begin
          ax[k+1] <= ax[k] - (ay[k] >>> k);
          ay[k+1] <= ay[k] + (ax[k] >>> k);
          az[k+1] <= az[k] - atan_q16(k);
        end else begin
          ax[k+1] <= ax[k] + (ay[k] >>> k);
          ay[k+1] <= ay[k] - (ax[k] >>> k);
          az[k+1] <= az[k] + atan_q16(k);
        end
      end
    end
  end

  // ---------------- output stage ----------------
  logic signed [ZW-1:0] zr;
  logic signed [17:0]   ang_wide;
  logic signed [15:0]   ang;
  logic        [15:0]   mag, cmd;

  always_comb begin
    // round half up to degrees * 256, then clamp to +-90 degrees
    zr       = az[N] + ZW'(128);
    ang_wide = 18'(zr >>> 8);
    if (azero[N]) begin
      ang = ypos[N] ? 16'(DEG90_Q8) : (yneg[N] ? -16'(DEG90_Q8) : '0);
    end else if (ang_wide > DEG90_Q8) begin
      ang = 16'(DEG90_Q8);
    end else if (ang_wide < -DEG90_Q8) begin
      ang = -16'(DEG90_Q8);
    end else begin
      ang = 16'(ang_wide);
    end
    mag = (ang < 0) ? 16'(-ang) : 16'(ang);
    cmd = (mag >> 4) | ((ang < 0) ? CMD_EAST : CMD_WEST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= av[N];
    end
    if (en) begin
      rotor_byte_high <= cmd[15:8];
      rotor_byte_low  <= cmd[7:0];
      rotor_angle     <= ang;
      range_error     <= aerr[N];
    end
  end

endmodule

@@ rtl/usals_checker.sv @@
// ----------------------------------------------------------------------------
// usals_checker
// Port-level checks on the rotor angle command results.
// ----------------------------------------------------------------------------
module usals_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [7:0]  rotor_byte_high,
  input logic signed [15:0] rotor_angle
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rotor_angle))
    else $error("stalled result dropped or changed");

  a_nibble: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotor_byte_high[7:4] == 4'hE) || (rotor_byte_high[7:4] == 4'hD))
    else $error("bad command nibble");

  a_east: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rotor_angle < 0) == (rotor_byte_high[7:4] == 4'hE)))
    else $error("direction nibble disagrees with angle sign");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotor_angle <= 16'sd23040) && (rotor_angle >= -16'sd23040))
    else $error("motor angle outside +-90 degrees");

endmodule

bind usals_rotor_angle_command usals_checker u_usals_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .rotor_byte_high(rotor_byte_high), .rotor_angle(rotor_angle)
);
